// ===== rtl/ar1fs_pkg.sv =====
package ar1fs_pkg;

   localparam int LEVEL_W = 24;
   localparam int SURP_W  = 25;
   localparam int CNT_W   = 13;
   localparam int LB_W    = 13;
   localparam int TOL_W   = 23;
   localparam int SUM_W   = 36;
   localparam int SQ_W    = 60;
   localparam int SSUM_W  = 38;
   localparam int SRC_W   = 2;
   localparam int MA_W    = 72;   // multiplicand: C, V, sums
   localparam int MB_W    = 38;   // multiplier: n, Sx, Sy, dev, samples
   localparam int PROD_W  = 112;
   localparam int DVD_W   = 112;
   localparam int DVS_W   = 88;
   localparam int QUO_W   = 26;
   localparam int DATA_W  = 80;

   localparam logic [SRC_W-1:0] SRC_NONE = 2'd0;
   localparam logic [SRC_W-1:0] SRC_PREV = 2'd1;
   localparam logic [SRC_W-1:0] SRC_AR1  = 2'd2;

   localparam logic CSR_LOOKBACK  = 1'b0;
   localparam logic CSR_TOLERANCE = 1'b1;

   localparam logic [QUO_W-1:0]   QUO_POS_LIMIT = 26'd8388607;
   localparam logic [QUO_W-1:0]   QUO_NEG_LIMIT = 26'd8388608;
   localparam logic [LEVEL_W-1:0] LEVEL_MAX     = 24'h7FFFFF;
   localparam logic [LEVEL_W-1:0] LEVEL_MIN     = 24'h800000;

   typedef enum logic [4:0] {
      OP_NONE, OP_LOAD, OP_ROUTE,
      OP_NSXY, OP_SXSY, OP_NSXX, OP_SXSX,
      OP_NP, OP_SYV, OP_CDEV, OP_NV, OP_FLAT, OP_FDIV,
      OP_SURP, OP_XY, OP_XX, OP_MDIV, OP_OUT
   } op_type;

   typedef struct packed {
      op_type op;
      logic   start;
      logic   commit;
   } cmd_type;

   typedef struct packed {
      logic             mul_done;
      logic             div_done;
      logic             fcast;
      logic             pairs;
      logic             v_pos;
      logic             end_run;
      logic             rsp_free;
      logic [SRC_W-1:0] src;
   } sts_type;

endpackage

// ===== rtl/ar1fs_mul.sv =====
module ar1fs_mul import ar1fs_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [MA_W-1:0]   a,
   input  logic signed [MB_W-1:0]   b,
   output logic                     done,
   output logic signed [PROD_W-1:0] prod
);

   localparam int MC_W = MA_W + MB_W;

   logic              run_ff, run_in;
   logic              neg_ff, neg_in;
   logic [MC_W-1:0]   mc_ff, mc_in;
   logic [MB_W-1:0]   mp_ff, mp_in;
   logic [MC_W-1:0]   acc_ff, acc_in;
   logic [MA_W-1:0]   a_mag;
   logic [MB_W-1:0]   b_mag;
   logic [PROD_W-1:0] prod_u;

   assign a_mag  = a[MA_W-1] ? MA_W'(-a) : a;
   assign b_mag  = b[MB_W-1] ? MB_W'(-b) : b;
   assign done   = run_ff && (mp_ff == '0);
   assign prod_u = PROD_W'(acc_ff);
   assign prod   = neg_ff ? (~prod_u + 1'b1) : prod_u;

   // shift-add, one multiplier bit a cycle, stops when no bits remain
   always_comb begin
      run_in = run_ff;
      neg_in = neg_ff;
      mc_in  = mc_ff;
      mp_in  = mp_ff;
      acc_in = acc_ff;
      if (start) begin
         run_in = 1'b1;
         neg_in = a[MA_W-1] ^ b[MB_W-1];
         mc_in  = MC_W'(a_mag);
         mp_in  = b_mag;
         acc_in = '0;
      end else if (run_ff) begin
         if (mp_ff == '0) begin
            run_in = 1'b0;
         end else begin
            if (mp_ff[0]) acc_in = acc_ff + mc_ff;
            mc_in = mc_ff << 1;
            mp_in = mp_ff >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) run_ff <= 1'b0;
      else       run_ff <= run_in;
      neg_ff <= neg_in;
      mc_ff  <= mc_in;
      mp_ff  <= mp_in;
      acc_ff <= acc_in;
   end

endmodule

// ===== rtl/ar1fs_div.sv =====
module ar1fs_div import ar1fs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             done,
   output logic [QUO_W-1:0] quo,
   output logic             big
);

   localparam int STEP_W = $clog2(DVD_W + 1);

   logic              run_ff, run_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DVD_W-1:0]  dvd_ff, dvd_in;
   logic [DVS_W-1:0]  dvs_ff, dvs_in;
   logic [DVS_W-1:0]  rem_ff, rem_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic              big_ff, big_in;
   logic [DVS_W:0]    trial;
   logic [DVS_W:0]    diff;

   assign done  = run_ff && (step_ff == '0);
   assign quo   = quo_ff;
   assign big   = big_ff;
   assign trial = {rem_ff, dvd_ff[DVD_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};

   // restoring division, one quotient bit a cycle; bits shifted past the
   // top of the quotient register are kept as an overflow flag
   always_comb begin
      run_in  = run_ff;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      big_in  = big_ff;
      if (start) begin
         run_in  = 1'b1;
         step_in = STEP_W'(DVD_W);
         dvd_in  = dividend;
         dvs_in  = divisor;
         rem_in  = '0;
         quo_in  = '0;
         big_in  = 1'b0;
      end else if (run_ff) begin
         if (step_ff == '0) begin
            run_in = 1'b0;
         end else begin
            step_in = step_ff - 1'b1;
            dvd_in  = dvd_ff << 1;
            big_in  = big_ff | quo_ff[QUO_W-1];
            if (!diff[DVS_W]) begin
               rem_in = diff[DVS_W-1:0];
               quo_in = {quo_ff[QUO_W-2:0], 1'b1};
            end else begin
               rem_in = trial[DVS_W-1:0];
               quo_in = {quo_ff[QUO_W-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) run_ff <= 1'b0;
      else       run_ff <= run_in;
      step_ff <= step_in;
      dvd_ff  <= dvd_in;
      dvs_ff  <= dvs_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      big_ff  <= big_in;
   end

endmodule

// ===== rtl/ar1fs_dp.sv =====
module ar1fs_dp import ar1fs_pkg::*; #(
   parameter int MAX_RUN       = 4096,
   parameter int FRACTION_BITS = 12
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output sts_type            sts,
   input  logic [LEVEL_W-1:0] req_level,
   input  logic               req_last,
   input  logic               csr_we,
   input  logic               csr_index,
   input  logic [TOL_W-1:0]   csr_data,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output logic [LEVEL_W-1:0] rsp_expectation,
   output logic [SURP_W-1:0]  rsp_surprise,
   output logic [SRC_W-1:0]   rsp_source,
   output logic               rsp_end,
   output logic [SURP_W-1:0]  rsp_mean,
   output logic               rsp_validated
);

   localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(((2 ** FRACTION_BITS) * 5 + 50) / 100);
   localparam logic [LB_W-1:0]  LB_RESET  = LB_W'(12);
   localparam logic [CNT_W-1:0] LAST_CNT  = CNT_W'(MAX_RUN - 1);

   // configuration
   logic [LB_W-1:0]  lookback_ff, lookback_in;
   logic [TOL_W-1:0] tol_ff, tol_in;

   // run state
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic signed [LEVEL_W-1:0] prev_ff, prev_in;
   logic signed [SUM_W-1:0]   sx_ff, sx_in, sy_ff, sy_in;
   logic signed [SQ_W-1:0]    sxy_ff, sxy_in, sxx_ff, sxx_in;
   logic signed [SSUM_W-1:0]  ssum_ff, ssum_in;

   // per-sample work registers
   logic signed [LEVEL_W-1:0] lvl_ff, lvl_in;
   logic                      last_ff, last_in;
   logic signed [LEVEL_W-1:0] exp_ff, exp_in;
   logic signed [SURP_W-1:0]  surp_ff, surp_in;
   logic [SRC_W-1:0]          src_ff, src_in;
   logic signed [PROD_W-1:0]  t_ff, t_in;
   logic signed [MA_W-1:0]    c_ff, c_in, v_ff, v_in;
   logic signed [MB_W-1:0]    dev_ff, dev_in;
   logic signed [PROD_W-1:0]  num_ff, num_in;
   logic [DVS_W-1:0]          den_ff, den_in;
   logic [SURP_W-1:0]         mean_ff, mean_in;
   logic                      valid_ff, valid_in;

   // result register
   logic                      rv_ff, rv_in;
   logic [LEVEL_W-1:0]        r_exp_ff, r_exp_in;
   logic [SURP_W-1:0]         r_surp_ff, r_surp_in;
   logic [SRC_W-1:0]          r_src_ff, r_src_in;
   logic                      r_end_ff, r_end_in;
   logic [SURP_W-1:0]         r_mean_ff, r_mean_in;
   logic                      r_val_ff, r_val_in;

   logic [LB_W-1:0]          lb;
   logic [CNT_W-1:0]         n;
   logic [CNT_W-1:0]         cnt1;
   logic [SRC_W-1:0]         src_now;
   logic                     end_now;
   logic                     is_div;
   logic signed [MA_W-1:0]   mul_a;
   logic signed [MB_W-1:0]   mul_b;
   logic                     mul_done;
   logic signed [PROD_W-1:0] prod;
   logic                     div_done;
   logic [QUO_W-1:0]         quo;
   logic                     big;
   logic [DVD_W-1:0]         dvd;
   logic [DVS_W-1:0]         dvs;
   logic                     num_neg;
   logic [PROD_W-1:0]        num_mag;
   logic                     ssum_neg;
   logic [SSUM_W-1:0]        ssum_mag;
   logic [LEVEL_W-1:0]       fc_sat;
   logic signed [SURP_W-1:0] surp_now;
   logic                     out_go;

   assign lb       = (lookback_ff == '0) ? LB_W'(1) : lookback_ff;
   assign n        = cnt_ff - 1'b1;
   assign cnt1     = cnt_ff + 1'b1;
   assign src_now  = (cnt_ff == '0) ? SRC_NONE : ((cnt_ff >= lb) ? SRC_AR1 : SRC_PREV);
   assign end_now  = last_ff || (cnt_ff >= LAST_CNT);
   assign is_div   = (cmd.op == OP_FDIV) || (cmd.op == OP_MDIV);
   assign out_go   = cmd.commit && (cmd.op == OP_OUT);

   assign num_neg  = num_ff[PROD_W-1];
   assign num_mag  = num_neg ? PROD_W'(-num_ff) : num_ff;
   assign ssum_neg = ssum_ff[SSUM_W-1];
   assign ssum_mag = ssum_neg ? SSUM_W'(-ssum_ff) : ssum_ff;
   assign surp_now = SURP_W'(lvl_ff) - SURP_W'(exp_ff);

   // rounded quotient back to a saturated sample
   always_comb begin
      if (num_neg) begin
         fc_sat = (big || (quo > QUO_NEG_LIMIT)) ? LEVEL_MIN : (~quo[LEVEL_W-1:0] + 1'b1);
      end else begin
         fc_sat = (big || (quo > QUO_POS_LIMIT)) ? LEVEL_MAX : quo[LEVEL_W-1:0];
      end
   end

   // shared multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      unique case (cmd.op)
         OP_NSXY: begin mul_a = MA_W'(sxy_ff);  mul_b = MB_W'(n);      end
         OP_SXSY: begin mul_a = MA_W'(sx_ff);   mul_b = MB_W'(sy_ff);  end
         OP_NSXX: begin mul_a = MA_W'(sxx_ff);  mul_b = MB_W'(n);      end
         OP_SXSX: begin mul_a = MA_W'(sx_ff);   mul_b = MB_W'(sx_ff);  end
         OP_NP:   begin mul_a = MA_W'(prev_ff); mul_b = MB_W'(n);      end
         OP_SYV:  begin mul_a = v_ff;           mul_b = MB_W'(sy_ff);  end
         OP_CDEV: begin mul_a = c_ff;           mul_b = dev_ff;        end
         OP_NV:   begin mul_a = v_ff;           mul_b = MB_W'(n);      end
         OP_XY:   begin mul_a = MA_W'(prev_ff); mul_b = MB_W'(lvl_ff); end
         OP_XX:   begin mul_a = MA_W'(prev_ff); mul_b = MB_W'(prev_ff); end
         default: begin mul_a = '0;             mul_b = '0;            end
      endcase
   end

   // divider operands: (2|x| + d) / (2d) rounds half away from zero
   always_comb begin
      if (cmd.op == OP_MDIV) begin
         dvd = DVD_W'({ssum_mag, 1'b0}) + DVD_W'(cnt1);
         dvs = DVS_W'({cnt1, 1'b0});
      end else begin
         dvd = DVD_W'({num_mag[PROD_W-2:0], 1'b0}) + DVD_W'(den_ff);
         dvs = {den_ff[DVS_W-2:0], 1'b0};
      end
   end

   ar1fs_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (cmd.start && !is_div),
      .a     (mul_a),
      .b     (mul_b),
      .done  (mul_done),
      .prod  (prod)
   );

   ar1fs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.start && is_div),
      .dividend (dvd),
      .divisor  (dvs),
      .done     (div_done),
      .quo      (quo),
      .big      (big)
   );

   always_comb begin
      lookback_in = lookback_ff;
      tol_in      = tol_ff;
      cnt_in      = cnt_ff;
      prev_in     = prev_ff;
      sx_in       = sx_ff;
      sy_in       = sy_ff;
      sxy_in      = sxy_ff;
      sxx_in      = sxx_ff;
      ssum_in     = ssum_ff;
      lvl_in      = lvl_ff;
      last_in     = last_ff;
      exp_in      = exp_ff;
      surp_in     = surp_ff;
      src_in      = src_ff;
      t_in        = t_ff;
      c_in        = c_ff;
      v_in        = v_ff;
      dev_in      = dev_ff;
      num_in      = num_ff;
      den_in      = den_ff;
      mean_in     = mean_ff;
      valid_in    = valid_ff;
      r_exp_in    = r_exp_ff;
      r_surp_in   = r_surp_ff;
      r_src_in    = r_src_ff;
      r_end_in    = r_end_ff;
      r_mean_in   = r_mean_ff;
      r_val_in    = r_val_ff;
      rv_in       = rsp_ready ? 1'b0 : rv_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_LOOKBACK:  lookback_in = csr_data[LB_W-1:0];
            CSR_TOLERANCE: tol_in      = csr_data;
            default:       tol_in      = tol_ff;
         endcase
      end

      if (cmd.commit) begin
         unique case (cmd.op)
            OP_LOAD: begin
               lvl_in  = req_level;
               last_in = req_last;
            end
            OP_ROUTE: begin
               src_in = src_now;
               exp_in = (src_now == SRC_PREV) ? prev_ff : '0;
            end
            OP_NSXY, OP_NSXX, OP_SYV: t_in = prod;
            OP_SXSY: c_in   = MA_W'(t_ff - prod);
            OP_SXSX: v_in   = MA_W'(t_ff - prod);
            OP_NP:   dev_in = MB_W'(prod - PROD_W'(sx_ff));
            OP_CDEV: num_in = t_ff + prod;
            OP_NV:   den_in = DVS_W'(prod);
            OP_FLAT: begin
               num_in = PROD_W'(sy_ff);
               den_in = DVS_W'(n);
            end
            OP_FDIV: exp_in = fc_sat;
            OP_SURP: begin
               surp_in = surp_now;
               ssum_in = ssum_ff + SSUM_W'(surp_now);
            end
            OP_XY: begin
               sxy_in = sxy_ff + SQ_W'(prod);
               sx_in  = sx_ff + SUM_W'(prev_ff);
               sy_in  = sy_ff + SUM_W'(lvl_ff);
            end
            OP_XX: sxx_in = sxx_ff + SQ_W'(prod);
            OP_MDIV: begin
               mean_in  = ssum_neg ? (~quo[SURP_W-1:0] + 1'b1) : quo[SURP_W-1:0];
               valid_in = !big && (quo < QUO_W'(tol_ff));
            end
            OP_OUT: begin
               rv_in     = 1'b1;
               r_exp_in  = exp_ff;
               r_surp_in = surp_ff;
               r_src_in  = src_ff;
               r_end_in  = end_now;
               r_mean_in = end_now ? mean_ff : '0;
               r_val_in  = end_now && valid_ff;
               if (end_now) begin
                  cnt_in  = '0;
                  prev_in = '0;
                  sx_in   = '0;
                  sy_in   = '0;
                  sxy_in  = '0;
                  sxx_in  = '0;
                  ssum_in = '0;
               end else begin
                  cnt_in  = cnt1;
                  prev_in = lvl_ff;
               end
            end
            default: rv_in = rv_in;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lookback_ff <= LB_RESET;
         tol_ff      <= TOL_RESET;
         cnt_ff      <= '0;
         prev_ff     <= '0;
         sx_ff       <= '0;
         sy_ff       <= '0;
         sxy_ff      <= '0;
         sxx_ff      <= '0;
         ssum_ff     <= '0;
         rv_ff       <= 1'b0;
      end else begin
         lookback_ff <= lookback_in;
         tol_ff      <= tol_in;
         cnt_ff      <= cnt_in;
         prev_ff     <= prev_in;
         sx_ff       <= sx_in;
         sy_ff       <= sy_in;
         sxy_ff      <= sxy_in;
         sxx_ff      <= sxx_in;
         ssum_ff     <= ssum_in;
         rv_ff       <= rv_in;
      end
      lvl_ff    <= lvl_in;
      last_ff   <= last_in;
      exp_ff    <= exp_in;
      surp_ff   <= surp_in;
      src_ff    <= src_in;
      t_ff      <= t_in;
      c_ff      <= c_in;
      v_ff      <= v_in;
      dev_ff    <= dev_in;
      num_ff    <= num_in;
      den_ff    <= den_in;
      mean_ff   <= mean_in;
      valid_ff  <= valid_in;
      r_exp_ff  <= r_exp_in;
      r_surp_ff <= r_surp_in;
      r_src_ff  <= r_src_in;
      r_end_ff  <= r_end_in;
      r_mean_ff <= r_mean_in;
      r_val_ff  <= r_val_in;
   end

   assign sts.mul_done = mul_done;
   assign sts.div_done = div_done;
   assign sts.fcast    = (cnt_ff >= CNT_W'(2));
   assign sts.pairs    = (cnt_ff != '0);
   assign sts.v_pos    = !v_ff[MA_W-1] && (v_ff != '0);
   assign sts.end_run  = end_now;
   assign sts.rsp_free = !rv_ff || rsp_ready;
   // routing is decided in the same cycle the source is latched
   assign sts.src      = src_now;

   assign rsp_valid       = rv_ff;
   assign rsp_expectation = r_exp_ff;
   assign rsp_surprise    = r_surp_ff;
   assign rsp_source      = r_src_ff;
   assign rsp_end         = r_end_ff;
   assign rsp_mean        = r_mean_ff;
   assign rsp_validated   = r_val_ff;

   a_out_room: assert property (@(posedge clock) disable iff (reset)
      out_go |-> (!rv_ff || rsp_ready))
      else $error("result overwritten while still held");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= LAST_CNT)
      else $error("sample count ran past the run limit");

   a_run_clear: assert property (@(posedge clock) disable iff (reset)
      (out_go && end_now) |=> (cnt_ff == '0) && (ssum_ff == '0))
      else $error("run state not cleared after final sample");

   a_unit_start: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !(mul_done || div_done))
      else $error("arithmetic unit restarted while finishing");

endmodule

// ===== rtl/ar1fs_ctrl.sv =====
module ar1fs_ctrl import ar1fs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [18:0] {
      ST_IDLE   = 19'b0000000000000000001,
      ST_ROUTE  = 19'b0000000000000000010,
      ST_NSXY   = 19'b0000000000000000100,
      ST_SXSY   = 19'b0000000000000001000,
      ST_NSXX   = 19'b0000000000000010000,
      ST_SXSX   = 19'b0000000000000100000,
      ST_BRANCH = 19'b0000000000001000000,
      ST_NP     = 19'b0000000000010000000,
      ST_SYV    = 19'b0000000000100000000,
      ST_CDEV   = 19'b0000000001000000000,
      ST_NV     = 19'b0000000010000000000,
      ST_FLAT   = 19'b0000000100000000000,
      ST_FDIV   = 19'b0000001000000000000,
      ST_SURP   = 19'b0000010000000000000,
      ST_XY     = 19'b0000100000000000000,
      ST_XX     = 19'b0001000000000000000,
      ST_MDIV   = 19'b0010000000000000000,
      ST_OUT    = 19'b0100000000000000000,
      ST_SPARE  = 19'b1000000000000000000
   } state_type;

   state_type state_ff, state_in, step_next;
   logic      issued_ff, issued_in;
   logic      multi;
   logic      unit_done;

   always_comb begin
      cmd.op     = OP_NONE;
      cmd.start  = 1'b0;
      cmd.commit = 1'b0;
      state_in   = state_ff;
      step_next  = state_ff;
      multi      = 1'b0;
      req_ready  = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready  = 1'b1;
            cmd.op     = OP_LOAD;
            cmd.commit = req_valid;
            if (req_valid) state_in = ST_ROUTE;
         end
         ST_ROUTE: begin
            cmd.op     = OP_ROUTE;
            cmd.commit = 1'b1;
            state_in   = (sts.src == SRC_AR1 && sts.fcast) ? ST_NSXY : ST_SURP;
         end
         ST_NSXY: begin cmd.op = OP_NSXY; multi = 1'b1; step_next = ST_SXSY; end
         ST_SXSY: begin cmd.op = OP_SXSY; multi = 1'b1; step_next = ST_NSXX; end
         ST_NSXX: begin cmd.op = OP_NSXX; multi = 1'b1; step_next = ST_SXSX; end
         ST_SXSX: begin cmd.op = OP_SXSX; multi = 1'b1; step_next = ST_BRANCH; end
         ST_BRANCH: state_in = sts.v_pos ? ST_NP : ST_FLAT;
         ST_NP:   begin cmd.op = OP_NP;   multi = 1'b1; step_next = ST_SYV; end
         ST_SYV:  begin cmd.op = OP_SYV;  multi = 1'b1; step_next = ST_CDEV; end
         ST_CDEV: begin cmd.op = OP_CDEV; multi = 1'b1; step_next = ST_NV; end
         ST_NV:   begin cmd.op = OP_NV;   multi = 1'b1; step_next = ST_FDIV; end
         ST_FLAT: begin
            cmd.op     = OP_FLAT;
            cmd.commit = 1'b1;
            state_in   = ST_FDIV;
         end
         ST_FDIV: begin cmd.op = OP_FDIV; multi = 1'b1; step_next = ST_SURP; end
         ST_SURP: begin
            cmd.op     = OP_SURP;
            cmd.commit = 1'b1;
            if (sts.pairs)        state_in = ST_XY;
            else if (sts.end_run) state_in = ST_MDIV;
            else                  state_in = ST_OUT;
         end
         ST_XY: begin cmd.op = OP_XY; multi = 1'b1; step_next = ST_XX; end
         ST_XX: begin
            cmd.op    = OP_XX;
            multi     = 1'b1;
            step_next = sts.end_run ? ST_MDIV : ST_OUT;
         end
         ST_MDIV: begin cmd.op = OP_MDIV; multi = 1'b1; step_next = ST_OUT; end
         ST_OUT: begin
            cmd.op     = OP_OUT;
            cmd.commit = sts.rsp_free;
            if (sts.rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase

      // multi-cycle steps: start the unit once, commit when it finishes
      unit_done = (cmd.op == OP_FDIV || cmd.op == OP_MDIV) ? sts.div_done : sts.mul_done;
      issued_in = 1'b0;
      if (multi) begin
         cmd.start  = !issued_ff;
         cmd.commit = issued_ff && unit_done;
         issued_in  = !(issued_ff && unit_done);
         if (issued_ff && unit_done) state_in = step_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         issued_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         issued_ff <= issued_in;
      end
   end

endmodule

// ===== rtl/ar1_forecast_surprise.sv =====
// Sequence: the AR(1) forecast runs up to eight shift-add multiplies and one division,
//   and the last sample of a run adds the mean division.
// Flow: one sample at a time; the next beat is taken once the result is in the output
//   register. The multiplier and divider are shared and bit-serial.
// Reset: synchronous, active high; clears run state, lookback to 12, tolerance to 0.05.
module ar1_forecast_surprise import ar1fs_pkg::*; #(
   parameter int MAX_RUN       = 4096,
   parameter int FRACTION_BITS = 12
) (
   input  logic               clock,
   input  logic               reset,
   // sample stream
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [LEVEL_W-1:0] req_tdata,   // [23:0] level
   input  logic               req_tlast,   // last sample of run
   // result stream
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [DATA_W-1:0]  rsp_tdata,   // [23:0] expectation, [48:24] surprise,
                                           // [73:49] mean_surprise, [74] validated
   output logic [SRC_W-1:0]   rsp_tuser,   // [1:0] source
   output logic               rsp_tlast,   // end_of_run
   // register writes
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,   // 0 lookback, 1 tolerance
   input  logic [TOL_W-1:0]   csr_data
);

   cmd_type            cmd;
   sts_type            sts;
   logic [LEVEL_W-1:0] expectation;
   logic [SURP_W-1:0]  surprise;
   logic [SURP_W-1:0]  mean_surprise;
   logic               validated;

   // register writes are always taken; software must write only while idle, the block does not enforce it
   assign csr_ready = 1'b1;

   // sequencer: at most one op per state, waits on the shared units
   ar1fs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // running sums, forecast math, result register
   ar1fs_dp #(
      .MAX_RUN       (MAX_RUN),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_level       (req_tdata),
      .req_last        (req_tlast),
      .csr_we          (csr_valid && csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_ready       (rsp_tready),
      .rsp_valid       (rsp_tvalid),
      .rsp_expectation (expectation),
      .rsp_surprise    (surprise),
      .rsp_source      (rsp_tuser),
      .rsp_end         (rsp_tlast),
      .rsp_mean        (mean_surprise),
      .rsp_validated   (validated)
   );

   // pack result beat, pad to whole bytes
   assign rsp_tdata = {5'b0, validated, mean_surprise, surprise, expectation};

endmodule
